[design/gnc_pkg.sv]
// shared types, constants and count function for the grid neighbor count block
package gnc_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int GRID_ROWS_W = 11;
    localparam int GRID_COLS_W = 6;
    localparam int CNT_W       = 4;
    localparam int JOB_DEPTH   = 4;

    localparam logic [CFG_IDX_W-1:0]   CFG_GRID_ROWS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]   CFG_GRID_COLS   = 1'b1;
    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RESET = 11'd32;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 6'd32;

    typedef struct packed {
        logic             has_a;
        logic [CNT_W-1:0] cnt_a;
        logic             has_b;
        logic [CNT_W-1:0] cnt_b;
        logic             flush;
    } job_ctrl_t;

    // up and down rows count all three taps, middle row skips the center
    function automatic logic [CNT_W-1:0] count8(
        input logic [2:0] up,
        input logic [2:0] mid,
        input logic [2:0] dn
    );
        logic [CNT_W-1:0] sum;
        sum = CNT_W'(up[0]) + CNT_W'(up[1]) + CNT_W'(up[2])
            + CNT_W'(mid[0]) + CNT_W'(mid[2])
            + CNT_W'(dn[0]) + CNT_W'(dn[1]) + CNT_W'(dn[2]);
        return sum;
    endfunction

endpackage

[design/gnc_front.sv]
// front end: takes cells, keeps the row stores and queues the counts each cell releases
module gnc_front #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024,
    parameter int CPW      = $clog2(MAX_COLS),
    parameter int RPW      = $clog2(MAX_ROWS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_clear,
    input  logic [CPW-1:0]        cols_last,
    input  logic [RPW-1:0]        rows_last,
    input  logic                  push,
    input  logic                  cell_req,
    input  logic                  q_full,
    output logic                  q_push,
    output gnc_pkg::job_ctrl_t    q_ctrl,
    output logic [MAX_COLS-1:0]   q_mid,
    output logic [MAX_COLS-1:0]   q_cur
);
    import gnc_pkg::*;

    logic [MAX_COLS-1:0] row_above_reg, row_above_next;
    logic [MAX_COLS-1:0] row_middle_reg, row_middle_next;
    logic [MAX_COLS-1:0] row_current_reg, row_current_next;
    logic [CPW-1:0]      col_pos_reg, col_pos_next;
    logic [RPW-1:0]      row_pos_reg, row_pos_next;

    logic                accept;
    logic [MAX_COLS-1:0] cur_new;
    logic                col_end;
    logic                row_end;
    logic [CPW-1:0]      col_prev;
    job_ctrl_t           ctrl;

    // left, center, right taps around column j; off-grid taps read as clear
    function automatic logic [2:0] tap3(
        input logic [MAX_COLS-1:0] row,
        input logic [CPW-1:0]      j,
        input logic [CPW-1:0]      last
    );
        logic [MAX_COLS:0] sh;
        sh = {row, 1'b0} >> j;
        return {sh[2] & (j < last), sh[1], sh[0]};
    endfunction

    assign accept   = push && !q_full;
    assign cur_new  = row_current_reg | (MAX_COLS'(cell_req) << col_pos_reg);
    assign col_end  = (col_pos_reg == cols_last);
    assign row_end  = (row_pos_reg == rows_last);
    assign col_prev = col_pos_reg - CPW'(1);

    always_comb
    begin
        ctrl.has_a = (row_pos_reg != '0) && (col_pos_reg != '0);
        ctrl.cnt_a = count8(tap3(row_above_reg, col_prev, cols_last),
                            tap3(row_middle_reg, col_prev, cols_last),
                            tap3(cur_new, col_prev, cols_last));
        ctrl.has_b = (row_pos_reg != '0) && col_end;
        ctrl.cnt_b = count8(tap3(row_above_reg, col_pos_reg, cols_last),
                            tap3(row_middle_reg, col_pos_reg, cols_last),
                            tap3(cur_new, col_pos_reg, cols_last));
        ctrl.flush = col_end && row_end;
    end

    assign q_push = accept && (ctrl.has_a || ctrl.has_b || ctrl.flush);
    assign q_ctrl = ctrl;
    assign q_mid  = row_middle_reg;
    assign q_cur  = cur_new;

    always_comb
    begin
        row_above_next   = row_above_reg;
        row_middle_next  = row_middle_reg;
        row_current_next = row_current_reg;
        col_pos_next     = col_pos_reg;
        row_pos_next     = row_pos_reg;
        if (cfg_clear)
        begin
            row_above_next   = '0;
            row_middle_next  = '0;
            row_current_next = '0;
            col_pos_next     = '0;
            row_pos_next     = '0;
        end
        else if (accept)
        begin
            if (col_end && row_end)
            begin
                row_above_next   = '0;
                row_middle_next  = '0;
                row_current_next = '0;
                col_pos_next     = '0;
                row_pos_next     = '0;
            end
            else if (col_end)
            begin
                row_above_next   = row_middle_reg;
                row_middle_next  = cur_new;
                row_current_next = '0;
                col_pos_next     = '0;
                row_pos_next     = row_pos_reg + RPW'(1);
            end
            else
            begin
                row_current_next = cur_new;
                col_pos_next     = col_pos_reg + CPW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_above_reg   <= '0;
            row_middle_reg  <= '0;
            row_current_reg <= '0;
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
        end
        else
        begin
            row_above_reg   <= row_above_next;
            row_middle_reg  <= row_middle_next;
            row_current_reg <= row_current_next;
            col_pos_reg     <= col_pos_next;
            row_pos_reg     <= row_pos_next;
        end
    end

endmodule

[design/gnc_job_queue.sv]
// short job queue between the front and back ends
module gnc_job_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    output logic [DW-1:0] rd_data,
    output logic          empty,
    output logic          full
);
    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + (AW+1)'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[design/gnc_back.sv]
// back end: walks queued jobs, one result per cycle into the output reg while pop keeps up
module gnc_back #(
    parameter int MAX_COLS = 32,
    parameter int CPW      = $clog2(MAX_COLS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [CPW-1:0]             cols_last,
    input  logic                       q_empty,
    input  gnc_pkg::job_ctrl_t         q_ctrl,
    input  logic [MAX_COLS-1:0]        q_mid,
    input  logic [MAX_COLS-1:0]        q_cur,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic [gnc_pkg::CNT_W-1:0]  neighbor_total,
    output logic                       run_last,
    output logic                       frame_end
);
    import gnc_pkg::*;

    typedef enum logic [2:0] {
        SEL_A = 3'b001,
        SEL_B = 3'b010,
        SEL_F = 3'b100
    } sel_t;

    sel_t             sel_reg, sel_next;
    logic [CPW-1:0]   k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_total_reg;
    logic             out_last_reg;
    logic             out_end_reg;

    logic             use_a;
    logic             use_b;
    logic             use_f;
    logic             k_end;
    logic             job_last;
    logic             advance;
    logic [CNT_W-1:0] flush_cnt;
    logic [CNT_W-1:0] total;

    function automatic logic [2:0] tap3(
        input logic [MAX_COLS-1:0] row,
        input logic [CPW-1:0]      j,
        input logic [CPW-1:0]      last
    );
        logic [MAX_COLS:0] sh;
        sh = {row, 1'b0} >> j;
        return {sh[2] & (j < last), sh[1], sh[0]};
    endfunction

    assign use_a     = (sel_reg == SEL_A) && q_ctrl.has_a;
    assign use_b     = !use_a && (sel_reg != SEL_F) && q_ctrl.has_b;
    assign use_f     = !use_a && !use_b;
    assign k_end     = (k_reg == cols_last);
    assign job_last  = use_a ? !(q_ctrl.has_b || q_ctrl.flush)
                     : use_b ? !q_ctrl.flush
                     : k_end;
    assign advance   = !q_empty && (!out_valid_reg || pop);
    assign q_pop     = advance && job_last;
    // final row: middle row above, flushed row in the center, nothing below
    assign flush_cnt = count8(tap3(q_mid, k_reg, cols_last),
                              tap3(q_cur, k_reg, cols_last), 3'b000);
    assign total     = use_a ? q_ctrl.cnt_a : use_b ? q_ctrl.cnt_b : flush_cnt;

    always_comb
    begin
        sel_next       = sel_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (job_last)
            begin
                sel_next = SEL_A;
                k_next   = '0;
            end
            else if (use_a)
                sel_next = SEL_B;
            else if (use_b)
            begin
                sel_next = SEL_F;
                k_next   = '0;
            end
            else
            begin
                sel_next = SEL_F;
                k_next   = k_reg + CPW'(1);
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= SEL_A;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_total_reg <= total;
            out_last_reg  <= job_last;
            out_end_reg   <= use_f && k_end;
        end
    end

    assign empty          = !out_valid_reg;
    assign neighbor_total = out_total_reg;
    assign run_last       = out_last_reg;
    assign frame_end      = out_end_reg;

    a_flush_job_only: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && use_f) |-> q_ctrl.flush)
        else $error("flush step on a job without flush");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (neighbor_total <= CNT_W'(8)))
        else $error("neighbor total above eight");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> run_last)
        else $error("frame end without run last");

    a_k_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != '0) |-> (sel_reg == SEL_F))
        else $error("column step outside flush");

endmodule

[design/grid_neighbor_count_core.sv]
// top level of the grid neighbor count block
// Cells of a binary grid enter in raster order, one per clock, through push/full; for each
// cell the count of set cells among its eight neighbors comes out through empty/pop once its
// 3x3 window is complete, with off-grid neighbors read as clear. An ordinary cell outside the
// first row and first column releases one count, the last cell of a row two, and the last
// cell of the frame those two plus the whole final row (grid_cols + 2 counts); run_last marks
// the last count of each cell and frame_end the final count of the frame. The output side
// delivers one count per clock while pop keeps up, so the sustained cell rate is one per
// clock except while a row end or frame end drains: a four-entry job queue between the front
// end and the result sequencer absorbs row ends, and full stays high while it is full. Counts
// pass through the job queue and the output register. A write to either register restarts
// the frame; out-of-range values are saturated to 1..MAX_ROWS and 1..MAX_COLS.
module grid_neighbor_count_core #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gnc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          cell_req,
    input  logic                          pop,
    output logic                          empty,
    output logic [gnc_pkg::CNT_W-1:0]     neighbor_total,
    output logic                          run_last,
    output logic                          frame_end
);
    import gnc_pkg::*;

    localparam int CPW = $clog2(MAX_COLS);
    localparam int RPW = $clog2(MAX_ROWS);
    localparam int RCW = ($clog2(MAX_ROWS + 1) > GRID_ROWS_W) ?
                         $clog2(MAX_ROWS + 1) : GRID_ROWS_W;
    localparam int QDW = $bits(job_ctrl_t) + 2 * MAX_COLS;

    logic [GRID_ROWS_W-1:0] grid_rows_reg, grid_rows_next;
    logic [GRID_COLS_W-1:0] grid_cols_reg, grid_cols_next;

    logic [RCW-1:0]         rows_ext;
    logic [RCW-1:0]         rows_sat;
    logic [GRID_COLS_W-1:0] cols_sat;
    logic [RPW-1:0]         rows_last;
    logic [CPW-1:0]         cols_last;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    logic                   q_full;
    job_ctrl_t              f_ctrl;
    logic [MAX_COLS-1:0]    f_mid;
    logic [MAX_COLS-1:0]    f_cur;
    job_ctrl_t              b_ctrl;
    logic [MAX_COLS-1:0]    b_mid;
    logic [MAX_COLS-1:0]    b_cur;
    logic [QDW-1:0]         q_wr_data;
    logic [QDW-1:0]         q_rd_data;

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_ROWS: grid_rows_next = cfg_data[GRID_ROWS_W-1:0];
                CFG_GRID_COLS: grid_cols_next = cfg_data[GRID_COLS_W-1:0];
                default:       grid_rows_next = grid_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RESET;
            grid_cols_reg <= GRID_COLS_RESET;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    assign rows_ext  = RCW'(grid_rows_reg);
    assign rows_sat  = (rows_ext == '0) ? RCW'(1)
                     : (rows_ext > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : rows_ext;
    assign cols_sat  = (grid_cols_reg == '0) ? GRID_COLS_W'(1)
                     : (grid_cols_reg > GRID_COLS_W'(MAX_COLS)) ? GRID_COLS_W'(MAX_COLS)
                     : grid_cols_reg;
    assign rows_last = RPW'(rows_sat - RCW'(1));
    assign cols_last = CPW'(cols_sat - GRID_COLS_W'(1));

    gnc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_we),
        .cols_last (cols_last),
        .rows_last (rows_last),
        .push      (push),
        .cell_req  (cell_req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctrl    (f_ctrl),
        .q_mid     (f_mid),
        .q_cur     (f_cur)
    );

    assign q_wr_data = {f_ctrl, f_mid, f_cur};

    gnc_job_queue #(
        .DW    (QDW),
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    assign {b_ctrl, b_mid, b_cur} = q_rd_data;

    gnc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cols_last      (cols_last),
        .q_empty        (q_empty),
        .q_ctrl         (b_ctrl),
        .q_mid          (b_mid),
        .q_cur          (b_cur),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .neighbor_total (neighbor_total),
        .run_last       (run_last),
        .frame_end      (frame_end)
    );

    assign full = q_full;

endmodule
